FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every check is sampled on aclk and is switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/pmm_pkg.sv
// ----------------------------------------------------------------------------
// pmm_pkg
// Types and constants shared by the MIDI parameter mapper: the binding
// layout, the configuration bundle, message codes and arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none

package pmm_pkg;

    // Configuration register indexes
    localparam logic [3:0] CFG_LISTEN = 4'd0;
    localparam logic [3:0] CFG_STEP   = 4'd1;
    localparam logic [3:0] CFG_BIND0  = 4'd2;

    localparam int NUM_BIND_REGS = 6;

    // Reset values
    localparam logic [15:0] STEP_RESET = 16'd131;

    // MIDI status types (high nibble)
    localparam logic [3:0] ST_CC       = 4'hB;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_NOTE_OFF = 4'h8;

    // Result event kinds
    localparam logic [1:0] EV_PARAM    = 2'd0;
    localparam logic [1:0] EV_NOTE_ON  = 2'd1;
    localparam logic [1:0] EV_NOTE_OFF = 2'd2;

    // Q1.15 full scale
    localparam logic [15:0] Q_ONE = 16'd32768;

    // Division by 127 as a reciprocal multiply: (x * ABS_RECIP) >> ABS_SHIFT
    // is exact for every x below 2^22.
    localparam logic [22:0] ABS_RECIP = 23'd4227331;
    localparam int          ABS_SHIFT = 29;
    localparam logic [21:0] ABS_ROUND = 22'd63;

    // Division of a note number by 12: (n * OCT_RECIP) >> OCT_SHIFT, exact
    // for n below 128.
    localparam logic [15:0] OCT_RECIP = 16'd171;
    localparam int          OCT_SHIFT = 11;
    localparam logic [6:0]  SEMIS     = 7'd12;

    // Frequency rounding: Q16 to Q10 with round half up
    localparam logic [30:0] FREQ_ROUND = 31'd32;
    localparam int          FREQ_SHIFT = 6;

    // One binding register, MSB first
    typedef struct packed {
        logic       en;
        logic [3:0] param;
        logic       rel;
        logic [6:0] ctrl;
    } binding_t;

    typedef struct packed {
        logic [3:0]                         listen;
        logic [15:0]                        step;
        binding_t [NUM_BIND_REGS-1:0]       bindings;
    } cfg_t;

    // Lowest octave in Q4.16 Hz, notes 0..11
    function automatic logic [19:0] semi_freq(input logic [3:0] semi);
        logic [19:0] f;
        case (semi)
            4'd0:    f = 20'd535809;
            4'd1:    f = 20'd567670;
            4'd2:    f = 20'd601425;
            4'd3:    f = 20'd637188;
            4'd4:    f = 20'd675077;
            4'd5:    f = 20'd715219;
            4'd6:    f = 20'd757749;
            4'd7:    f = 20'd802807;
            4'd8:    f = 20'd850544;
            4'd9:    f = 20'd901120;
            4'd10:   f = 20'd954703;
            4'd11:   f = 20'd1011473;
            default: f = 20'd0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: design/midi_message_param_mapper.sv
// ----------------------------------------------------------------------------
// midi_message_param_mapper
// Decodes MIDI control change and note messages for one listen channel.
// Control changes update a per-part parameter mirror through the bindings;
// notes report an equal-temperament frequency in Q14.10.
// ----------------------------------------------------------------------------
// Pipeline: stage A, stage B with the mirror read-modify-write, and the
// output register. Throughput: one item per cycle while m_ready does not
// stall the output; the mirror's read and write ports serve every cycle,
// with forwarding between back-to-back items on the same entry.
// Reset: config registers take their defaults, all mirror entries read as
// zero at once (valid bits), pipeline and output are emptied.
`default_nettype none

module midi_message_param_mapper import pmm_pkg::*; #(
    parameter int NUM_PARTS    = 4,
    parameter int NUM_PARAMS   = 16,
    parameter int NUM_BINDINGS = 6
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_status_byte,
    input  wire logic [6:0]  s_data_one,
    input  wire logic [6:0]  s_data_two,
    input  wire logic [3:0]  s_part_index,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_event_kind,
    output logic [3:0]       m_event_part,
    output logic [3:0]       m_param_index,
    output logic [15:0]      m_param_value,
    output logic [23:0]      m_note_frequency
);

`include "assert_macros.svh"

    localparam int SLOTS  = NUM_PARTS * NUM_PARAMS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    cfg_t cfg;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    pmm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_addr (cfg_addr),
        .wr_data (cfg_wdata),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Handshake and pipeline advance
    // ------------------------------------------------------------------
    logic a_valid_reg;
    logic b_valid_reg;
    logic m_valid_reg;
    logic out_free;
    logic b_free;
    logic a_go;
    logic b_go;
    logic s_go;

    assign out_free = !m_valid_reg || m_ready;
    assign b_free   = !b_valid_reg || out_free;
    assign a_go     = a_valid_reg && b_free;
    assign b_go     = b_valid_reg && out_free;
    assign s_ready  = !a_valid_reg || b_free;
    assign s_go     = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Decode: filter, binding match, slot and octave split
    // ------------------------------------------------------------------
    logic [3:0]  d_type;
    logic        d_ch_ok;
    logic        d_part_ok;
    logic        d_hit;
    binding_t    d_sel;
    logic        d_param_ok;
    logic        d_is_cc;
    logic        d_is_on;
    logic        d_is_off;
    logic        d_keep;
    logic [1:0]  d_kind;
    logic [7:0]  d_slot_full;
    logic [15:0] d_oct_prod;
    logic [3:0]  d_oct;
    logic [6:0]  d_semi_full;

    always_comb begin
        d_type    = s_status_byte[7:4];
        d_ch_ok   = (s_status_byte[3:0] == cfg.listen);
        d_part_ok = ({1'b0, s_part_index} < 5'(NUM_PARTS));

        // Scan from the top so the lowest matching binding wins
        d_hit = 1'b0;
        d_sel = '0;
        for (int i = NUM_BINDINGS - 1; i >= 0; i--) begin
            if (cfg.bindings[i].en && (cfg.bindings[i].ctrl == s_data_one)) begin
                d_hit = 1'b1;
                d_sel = cfg.bindings[i];
            end
        end
        d_param_ok = ({1'b0, d_sel.param} < 5'(NUM_PARAMS));

        d_is_cc  = (d_type == ST_CC) && d_hit && d_param_ok;
        d_is_on  = (d_type == ST_NOTE_ON);
        d_is_off = (d_type == ST_NOTE_OFF);
        d_keep   = d_ch_ok && d_part_ok && (d_is_cc || d_is_on || d_is_off);

        if (d_is_cc) begin
            d_kind = EV_PARAM;
        end else if (d_is_on && (s_data_two != 7'd0)) begin
            d_kind = EV_NOTE_ON;
        end else begin
            d_kind = EV_NOTE_OFF;
        end

        d_slot_full = 8'(s_part_index) * 8'(NUM_PARAMS) + 8'(d_sel.param);

        d_oct_prod  = 16'(s_data_one) * OCT_RECIP;
        d_oct       = d_oct_prod[OCT_SHIFT+3:OCT_SHIFT];
        d_semi_full = s_data_one - 7'(d_oct) * SEMIS;
    end

    // ------------------------------------------------------------------
    // Stage A: mirror read, absolute scaling, frequency
    // ------------------------------------------------------------------
    logic [1:0]        a_kind_reg;
    logic [3:0]        a_part_reg;
    logic [3:0]        a_param_reg;
    logic              a_rel_reg;
    logic [SLOT_W-1:0] a_slot_reg;
    logic [6:0]        a_d2_reg;
    logic [3:0]        a_oct_reg;
    logic [3:0]        a_semi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_ready) begin
            a_valid_reg <= s_go && d_keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_go) begin
            a_kind_reg  <= d_kind;
            a_part_reg  <= s_part_index;
            a_param_reg <= d_is_cc ? d_sel.param : 4'd0;
            a_rel_reg   <= d_sel.rel;
            a_slot_reg  <= d_slot_full[SLOT_W-1:0];
            a_d2_reg    <= s_data_two;
            a_oct_reg   <= d_oct;
            a_semi_reg  <= d_semi_full[3:0];
        end
    end

    logic [21:0] a_abs_num;
    logic [44:0] a_abs_prod;
    logic [30:0] a_freq_shl;
    logic [30:0] a_freq_rnd;
    logic [23:0] a_freq;

    always_comb begin
        // value/127 rounded to nearest, via reciprocal multiply
        a_abs_num  = {a_d2_reg, 15'd0} + ABS_ROUND;
        a_abs_prod = 45'(a_abs_num) * 45'(ABS_RECIP);

        // Lowest-octave frequency shifted up by the octave, Q16 to Q10
        a_freq_shl = 31'(semi_freq(a_semi_reg)) << a_oct_reg;
        a_freq_rnd = (a_freq_shl + FREQ_ROUND) >> FREQ_SHIFT;
        a_freq     = a_freq_rnd[23:0];
    end

    // ------------------------------------------------------------------
    // Stage B: read-modify-write of the mirror
    // ------------------------------------------------------------------
    logic [1:0]        b_kind_reg;
    logic [3:0]        b_part_reg;
    logic [3:0]        b_param_reg;
    logic              b_rel_reg;
    logic [SLOT_W-1:0] b_slot_reg;
    logic [6:0]        b_d2_reg;
    logic [15:0]       b_abs_reg;
    logic [23:0]       b_freq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_free) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_go) begin
            b_kind_reg  <= a_kind_reg;
            b_part_reg  <= a_part_reg;
            b_param_reg <= a_param_reg;
            b_rel_reg   <= a_rel_reg;
            b_slot_reg  <= a_slot_reg;
            b_d2_reg    <= a_d2_reg;
            b_abs_reg   <= a_abs_prod[ABS_SHIFT+15:ABS_SHIFT];
            b_freq_reg  <= (a_kind_reg == EV_PARAM) ? 24'd0 : a_freq;
        end
    end

    logic [15:0]        b_mirror;
    logic signed [23:0] b_rel_prod;
    logic signed [23:0] b_rel_sum;
    logic [15:0]        b_rel_val;
    logic [15:0]        b_new_val;
    logic               b_wr_en;

    pmm_mirror #(
        .DEPTH  (SLOTS),
        .ADDR_W (SLOT_W)
    ) u_mirror (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (a_go),
        .rd_addr (a_slot_reg),
        .rd_data (b_mirror),
        .wr_en   (b_wr_en),
        .wr_addr (b_slot_reg),
        .wr_data (b_new_val)
    );

    always_comb begin
        // Signed 7-bit delta times step, added to the stored value, clamped
        b_rel_prod = $signed({{17{b_d2_reg[6]}}, b_d2_reg}) * $signed({8'd0, cfg.step});
        b_rel_sum  = b_rel_prod + $signed({8'd0, b_mirror});
        if (b_rel_sum[23]) begin
            b_rel_val = 16'd0;
        end else if (b_rel_sum > $signed({8'd0, Q_ONE})) begin
            b_rel_val = Q_ONE;
        end else begin
            b_rel_val = b_rel_sum[15:0];
        end

        if (b_kind_reg != EV_PARAM) begin
            b_new_val = 16'd0;
        end else if (b_rel_reg) begin
            b_new_val = b_rel_val;
        end else begin
            b_new_val = b_abs_reg;
        end

        b_wr_en = b_go && (b_kind_reg == EV_PARAM);
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [1:0]  m_kind_reg;
    logic [3:0]  m_part_reg;
    logic [3:0]  m_param_reg;
    logic [15:0] m_value_reg;
    logic [23:0] m_freq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_go) begin
            m_kind_reg  <= b_kind_reg;
            m_part_reg  <= b_part_reg;
            m_param_reg <= b_param_reg;
            m_value_reg <= b_new_val;
            m_freq_reg  <= b_freq_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_event_kind     = m_kind_reg;
    assign m_event_part     = m_part_reg;
    assign m_param_index    = m_param_reg;
    assign m_param_value    = m_value_reg;
    assign m_note_frequency = m_freq_reg;

    `ASSERT_IMPL(a_stall_chain, !s_ready, a_valid_reg && b_valid_reg && m_valid_reg && !m_ready, "input stalled without a full pipeline")
    `ASSERT_IMPL(a_param_shape, m_valid_reg && (m_kind_reg == EV_PARAM), (m_freq_reg == 24'd0) && (m_value_reg <= Q_ONE), "parameter write out of shape")
    `ASSERT_IMPL(a_note_shape, m_valid_reg && (m_kind_reg != EV_PARAM), (m_param_reg == 4'd0) && (m_value_reg == 16'd0), "note event carries a parameter")
    `ASSERT_IMPL(a_part_range, m_valid_reg, {1'b0, m_part_reg} < 5'(NUM_PARTS), "result for a part out of range")

endmodule

`default_nettype wire

FILE: design/pmm_cfg.sv
// ----------------------------------------------------------------------------
// pmm_cfg
// Configuration register file: listen channel, relative step and the six
// controller bindings. Writes beyond the register list are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module pmm_cfg import pmm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        wr_en,
    input  wire logic [3:0]  wr_addr,
    input  wire logic [15:0] wr_data,
    output cfg_t             cfg
);

    logic [3:0]                   listen_reg;
    logic [15:0]                  step_reg;
    binding_t [NUM_BIND_REGS-1:0] bind_reg;

    // Decode the index and update the addressed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            listen_reg <= '0;
            step_reg   <= STEP_RESET;
            bind_reg   <= '0;
        end else if (wr_en) begin
            if (wr_addr == CFG_LISTEN) begin
                listen_reg <= wr_data[3:0];
            end
            if (wr_addr == CFG_STEP) begin
                step_reg <= wr_data;
            end
            for (int i = 0; i < NUM_BIND_REGS; i++) begin
                if (wr_addr == CFG_BIND0 + 4'(i)) begin
                    bind_reg[i] <= binding_t'(wr_data[12:0]);
                end
            end
        end
    end

    assign cfg.listen   = listen_reg;
    assign cfg.step     = step_reg;
    assign cfg.bindings = bind_reg;

endmodule

`default_nettype wire

FILE: design/pmm_mirror.sv
// ----------------------------------------------------------------------------
// pmm_mirror
// Parameter mirror store: synchronous single-read, single-write memory with
// per-entry valid bits (an unwritten entry reads as zero) and write-to-read
// forwarding when a read and a write hit the same entry on one edge.
// ----------------------------------------------------------------------------
`default_nettype none

module pmm_mirror #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [15:0]            rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [15:0]       wr_data
);

`include "assert_macros.svh"

    logic [15:0]      mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [15:0]      ram_q_reg;
    logic             vld_q_reg;
    logic             fwd_reg;
    logic [15:0]      fwd_data_reg;

    // Memory array: write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            ram_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // Valid bits and forwarding flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
            fwd_reg   <= 1'b0;
        end else begin
            if (rd_en) begin
                vld_q_reg <= vld_reg[rd_addr];
                fwd_reg   <= wr_en && (wr_addr == rd_addr);
            end
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Forwarded write wins over the stale array word
    assign rd_data = fwd_reg   ? fwd_data_reg :
                     vld_q_reg ? ram_q_reg    : 16'd0;

    `ASSERT_NEXT(a_fwd_same_entry, rd_en && wr_en && (rd_addr == wr_addr), rd_data == $past(wr_data), "mirror read missed a same-edge write")

endmodule

`default_nettype wire
